// ===== rtl/segix_pkg.sv =====
// Shared widths, constants and types of the segment intersection block.
package segix_pkg;

	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 16;

	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int WIDE_BITS = 2 * COORD_BITS + 3;
	localparam int MAG_BITS  = WIDE_BITS - 1;
	localparam int REM_BITS  = MAG_BITS + 1;
	localparam int QUO_BITS  = T_FRAC_BITS + 1;
	localparam int DIV_STAGES = T_FRAC_BITS + 1;
	localparam int SCALE_BITS = QUO_BITS + COORD_BITS;

	localparam int IN_FIELDS     = 8;
	localparam int IN_DATA_BITS  = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// One classified item handed from the front end to the back end.
	typedef struct packed {
		logic                        hit;
		logic signed [COORD_BITS-1:0] p0x;
		logic signed [COORD_BITS-1:0] p0y;
		logic signed [DIFF_BITS-1:0]  d10x;
		logic signed [DIFF_BITS-1:0]  d10y;
		logic [MAG_BITS-1:0]          tmag;
		logic [MAG_BITS-1:0]          dmag;
	} job_t;

	// Side data that rides along the divider stages.
	typedef struct packed {
		logic                        hit;
		logic signed [COORD_BITS-1:0] p0x;
		logic signed [COORD_BITS-1:0] p0y;
		logic                        negx;
		logic                        negy;
		logic [COORD_BITS-1:0]        magx;
		logic [COORD_BITS-1:0]        magy;
	} carry_t;

endpackage

// ===== rtl/segment_intersection_top.sv =====
// Top level of the 2D segment intersection block.
//
// Each input beat carries two segments, p0-p1 and p2-p3, as signed fixed-point
// coordinates with 4 fraction bits. The block forms the cross-product
// denominator and both numerators exactly, reports a miss when the denominator
// is zero or a numerator fails the sign-dependent range test, and otherwise
// returns p0 + t*(p1-p0), where t is the truncated ratio of the numerator to
// the denominator with 16 fraction bits and the scaled step is truncated toward
// zero. A miss returns a zero point. One result beat leaves for every input
// beat, in order. The block takes one beat per cycle while it is not stalled;
// a beat passes three front stages for differences, products and range
// tests, the four-entry queue, seventeen stages of the restoring divider
// (one quotient bit each), one multiply stage and the output register. The
// divider pipeline sets the latency; the queue lets the front keep accepting
// while the output side is stalled, until the queue is full.
module segment_intersection_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// Fields from bit 0 up: first_start_x, first_start_y, first_end_x,
	// first_end_y, second_start_x, second_start_y, second_end_x, second_end_y.
	input  logic [segix_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// Fields from bit 0 up: cross_x, cross_y.
	output logic [segix_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
	// Field: hit.
	output logic                                   m_axis_tuser
);
	import segix_pkg::*;

	logic  push, queue_full, pop_valid, pop_ready;
	job_t  push_job, pop_job;
	logic signed [COORD_BITS-1:0] cross_x, cross_y;

	segix_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push       (push),
		.job        (push_job),
		.queue_full (queue_full)
	);

	segix_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job)
	);

	segix_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pop_valid),
		.in_ready  (pop_ready),
		.in_job    (pop_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_hit   (m_axis_tuser),
		.out_x     (cross_x),
		.out_y     (cross_y)
	);

	assign m_axis_tdata = OUT_DATA_BITS'({cross_y, cross_x});

endmodule

// ===== rtl/segix_front.sv =====
// Front end: differences, cross products and the hit classification.
module segix_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [segix_pkg::IN_DATA_BITS-1:0] in_data,
	output logic                               push,
	output segix_pkg::job_t                    job,
	input  logic                               queue_full
);
	import segix_pkg::*;

	logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, ex, ey;
	logic adv;

	logic v_s1, v_s2, v_s3;
	logic signed [COORD_BITS-1:0] p0x_s1, p0y_s1, p0x_s2, p0y_s2, p0x_s3, p0y_s3;
	logic signed [DIFF_BITS-1:0]  d10x_s1, d10y_s1, d32x_s1, d32y_s1, d02x_s1, d02y_s1;
	logic signed [DIFF_BITS-1:0]  d10x_s2, d10y_s2, d10x_s3, d10y_s3;
	logic signed [PROD_BITS-1:0]  den_a_s2, den_b_s2, sn_a_s2, sn_b_s2, tn_a_s2, tn_b_s2;
	logic signed [WIDE_BITS-1:0]  den_s3, sn_s3, tn_s3;
	logic pos, ok;

	assign ax = in_data[0*COORD_BITS +: COORD_BITS];
	assign ay = in_data[1*COORD_BITS +: COORD_BITS];
	assign bx = in_data[2*COORD_BITS +: COORD_BITS];
	assign by = in_data[3*COORD_BITS +: COORD_BITS];
	assign cx = in_data[4*COORD_BITS +: COORD_BITS];
	assign cy = in_data[5*COORD_BITS +: COORD_BITS];
	assign ex = in_data[6*COORD_BITS +: COORD_BITS];
	assign ey = in_data[7*COORD_BITS +: COORD_BITS];

	// The whole front pipeline moves together; it only stops when its last
	// stage holds an item and the queue has no room.
	assign adv      = !(v_s3 && queue_full);
	assign in_ready = adv;
	assign push     = v_s3 && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0x_s1  <= ax;
			p0y_s1  <= ay;
			d10x_s1 <= DIFF_BITS'(bx) - DIFF_BITS'(ax);
			d10y_s1 <= DIFF_BITS'(by) - DIFF_BITS'(ay);
			d32x_s1 <= DIFF_BITS'(ex) - DIFF_BITS'(cx);
			d32y_s1 <= DIFF_BITS'(ey) - DIFF_BITS'(cy);
			d02x_s1 <= DIFF_BITS'(ax) - DIFF_BITS'(cx);
			d02y_s1 <= DIFF_BITS'(ay) - DIFF_BITS'(cy);

			p0x_s2   <= p0x_s1;
			p0y_s2   <= p0y_s1;
			d10x_s2  <= d10x_s1;
			d10y_s2  <= d10y_s1;
			den_a_s2 <= d10x_s1 * d32y_s1;
			den_b_s2 <= d32x_s1 * d10y_s1;
			sn_a_s2  <= d10x_s1 * d02y_s1;
			sn_b_s2  <= d10y_s1 * d02x_s1;
			tn_a_s2  <= d32x_s1 * d02y_s1;
			tn_b_s2  <= d32y_s1 * d02x_s1;

			p0x_s3  <= p0x_s2;
			p0y_s3  <= p0y_s2;
			d10x_s3 <= d10x_s2;
			d10y_s3 <= d10y_s2;
			den_s3  <= WIDE_BITS'(den_a_s2) - WIDE_BITS'(den_b_s2);
			sn_s3   <= WIDE_BITS'(sn_a_s2) - WIDE_BITS'(sn_b_s2);
			tn_s3   <= WIDE_BITS'(tn_a_s2) - WIDE_BITS'(tn_b_s2);
		end
	end

	// Sign-dependent range tests: a positive denominator keeps both end
	// points, a negative one excludes them.
	always_comb begin
		pos = (den_s3 != '0) && !den_s3[WIDE_BITS-1];
		ok  = (den_s3 != '0)
			&& ((sn_s3 < 0) != pos)
			&& ((tn_s3 < 0) != pos)
			&& ((sn_s3 > den_s3) != pos)
			&& ((tn_s3 > den_s3) != pos);

		job.hit  = ok;
		job.p0x  = p0x_s3;
		job.p0y  = p0y_s3;
		job.d10x = d10x_s3;
		job.d10y = d10y_s3;
		job.tmag = tn_s3[WIDE_BITS-1] ? MAG_BITS'(-tn_s3) : MAG_BITS'(tn_s3);
		job.dmag = den_s3[WIDE_BITS-1] ? MAG_BITS'(-den_s3) : MAG_BITS'(den_s3);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push && job.hit |-> (job.dmag != '0) && (job.tmag <= job.dmag))
		else $error("front: hit with numerator beyond denominator");

endmodule

// ===== rtl/segix_fifo.sv =====
// Short queue that decouples the front end from the divider back end.
module segix_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  segix_pkg::job_t push_job,
	output logic            full,
	output logic            pop_valid,
	input  logic            pop_ready,
	output segix_pkg::job_t pop_job
);
	import segix_pkg::*;

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               pop;

	assign full      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("fifo: write into a full queue");

endmodule

// ===== rtl/segix_back.sv =====
// Back end: pipelined restoring divider, scaling multiply and output register.
module segix_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  segix_pkg::job_t                       in_job,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  out_hit,
	output logic signed [segix_pkg::COORD_BITS-1:0] out_x,
	output logic signed [segix_pkg::COORD_BITS-1:0] out_y
);
	import segix_pkg::*;

	logic adv;

	logic [DIV_STAGES-1:0] div_valid_s;
	logic [REM_BITS-1:0]   div_rem_s  [DIV_STAGES];
	logic [QUO_BITS-1:0]   div_quo_s  [DIV_STAGES];
	logic [MAG_BITS-1:0]   div_den_s  [DIV_STAGES];
	carry_t                div_info_s [DIV_STAGES];

	logic [REM_BITS-1:0] rem_nxt [DIV_STAGES];
	logic [QUO_BITS-1:0] quo_nxt [DIV_STAGES];
	logic [MAG_BITS-1:0] den_nxt [DIV_STAGES];
	carry_t              info_in;
	logic signed [DIFF_BITS-1:0] negd10x, negd10y;

	logic                  mul_valid_s;
	logic [SCALE_BITS-1:0] prod_x_s, prod_y_s;
	carry_t                mul_info_s;

	logic [COORD_BITS-1:0]        step_x, step_y;
	logic signed [COORD_BITS:0]   sum_x, sum_y;

	logic                         out_valid_q, out_hit_q;
	logic signed [COORD_BITS-1:0] out_x_q, out_y_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	assign negd10x = -in_job.d10x;
	assign negd10y = -in_job.d10y;

	always_comb begin
		info_in.hit  = in_job.hit;
		info_in.p0x  = in_job.p0x;
		info_in.p0y  = in_job.p0y;
		info_in.negx = in_job.d10x[DIFF_BITS-1];
		info_in.negy = in_job.d10y[DIFF_BITS-1];
		info_in.magx = in_job.d10x[DIFF_BITS-1] ? COORD_BITS'(negd10x)
			: COORD_BITS'(in_job.d10x);
		info_in.magy = in_job.d10y[DIFF_BITS-1] ? COORD_BITS'(negd10y)
			: COORD_BITS'(in_job.d10y);
	end

	// One quotient bit per stage. The first stage yields the integer bit,
	// the rest shift the remainder and yield one fraction bit each.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [REM_BITS-1:0] r_in;
		logic [QUO_BITS-1:0] q_in;
		logic [MAG_BITS-1:0] d_in;
		logic                ge;

		if (k == 0) begin : g_first
			assign r_in = {1'b0, in_job.tmag};
			assign q_in = '0;
			assign d_in = in_job.dmag;
		end else begin : g_rest
			assign r_in = {div_rem_s[k-1][REM_BITS-2:0], 1'b0};
			assign q_in = div_quo_s[k-1];
			assign d_in = div_den_s[k-1];
		end

		assign ge         = (r_in >= {1'b0, d_in});
		assign rem_nxt[k] = ge ? r_in - {1'b0, d_in} : r_in;
		assign quo_nxt[k] = {q_in[QUO_BITS-2:0], ge};
		assign den_nxt[k] = d_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_valid_s <= '0;
			mul_valid_s <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			div_valid_s <= {div_valid_s[DIV_STAGES-2:0], in_valid};
			mul_valid_s <= div_valid_s[DIV_STAGES-1];
			out_valid_q <= mul_valid_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				div_rem_s[k] <= rem_nxt[k];
				div_quo_s[k] <= quo_nxt[k];
				div_den_s[k] <= den_nxt[k];
			end
			div_info_s[0] <= info_in;
			for (int k = 1; k < DIV_STAGES; k++) begin
				div_info_s[k] <= div_info_s[k-1];
			end

			prod_x_s   <= SCALE_BITS'(div_quo_s[DIV_STAGES-1])
				* SCALE_BITS'(div_info_s[DIV_STAGES-1].magx);
			prod_y_s   <= SCALE_BITS'(div_quo_s[DIV_STAGES-1])
				* SCALE_BITS'(div_info_s[DIV_STAGES-1].magy);
			mul_info_s <= div_info_s[DIV_STAGES-1];

			out_hit_q <= mul_info_s.hit;
			out_x_q   <= mul_info_s.hit ? sum_x[COORD_BITS-1:0] : '0;
			out_y_q   <= mul_info_s.hit ? sum_y[COORD_BITS-1:0] : '0;
		end
	end

	// The scaled step is truncated toward zero and applied with the sign
	// of the first segment's direction.
	assign step_x = prod_x_s[T_FRAC_BITS +: COORD_BITS];
	assign step_y = prod_y_s[T_FRAC_BITS +: COORD_BITS];
	assign sum_x  = mul_info_s.negx
		? (COORD_BITS+1)'(mul_info_s.p0x) - $signed({1'b0, step_x})
		: (COORD_BITS+1)'(mul_info_s.p0x) + $signed({1'b0, step_x});
	assign sum_y  = mul_info_s.negy
		? (COORD_BITS+1)'(mul_info_s.p0y) - $signed({1'b0, step_y})
		: (COORD_BITS+1)'(mul_info_s.p0y) + $signed({1'b0, step_y});

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		div_valid_s[DIV_STAGES-1] && div_info_s[DIV_STAGES-1].hit
		|-> div_rem_s[DIV_STAGES-1] < {1'b0, div_den_s[DIV_STAGES-1]})
		else $error("back: divider remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_hit_q |-> (out_x_q == '0) && (out_y_q == '0))
		else $error("back: miss result with nonzero point");

endmodule

// ===== bench/segment_intersection_top_tb.sv =====
// Self-checking testbench for the segment intersection block with a stream driver and monitor.
module segment_intersection_top_tb;
	import segix_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;

	// One input beat: first_start_x sits in the lowest bits, second_end_y in the highest.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] second_end_y;
		logic signed [COORD_BITS-1:0] second_end_x;
		logic signed [COORD_BITS-1:0] second_start_y;
		logic signed [COORD_BITS-1:0] second_start_x;
		logic signed [COORD_BITS-1:0] first_end_y;
		logic signed [COORD_BITS-1:0] first_end_x;
		logic signed [COORD_BITS-1:0] first_start_y;
		logic signed [COORD_BITS-1:0] first_start_x;
	} seg_pair_t;

	typedef struct packed {
		logic                         hit;
		logic signed [COORD_BITS-1:0] cross_x;
		logic signed [COORD_BITS-1:0] cross_y;
	} crossing_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic                     m_axis_tuser;

	seg_pair_t pending_pairs[$];
	crossing_t expected_points[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	segment_intersection_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint unsigned abs_of(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// Exact cross products, sign-dependent range tests, then a restoring division
	// of |t| by |d| and a step from p0 truncated toward zero.
	function automatic crossing_t predict_crossing(seg_pair_t p);
		longint ax, ay, bx, by, cx, cy, ex, ey;
		longint d10x, d10y, d32x, d32y, d02x, d02y, den, sn, tn;
		longint unsigned dmag, rem, quo, stepx, stepy;
		bit pos;
		crossing_t r;
		r = '0;
		ax = $signed(p.first_start_x);
		ay = $signed(p.first_start_y);
		bx = $signed(p.first_end_x);
		by = $signed(p.first_end_y);
		cx = $signed(p.second_start_x);
		cy = $signed(p.second_start_y);
		ex = $signed(p.second_end_x);
		ey = $signed(p.second_end_y);
		d10x = bx - ax;
		d10y = by - ay;
		d32x = ex - cx;
		d32y = ey - cy;
		d02x = ax - cx;
		d02y = ay - cy;
		den = d10x * d32y - d32x * d10y;
		if (den == 0)
			return r;
		pos = (den > 0);
		sn = d10x * d02y - d10y * d02x;
		tn = d32x * d02y - d32y * d02x;
		if (((sn < 0) == pos) || ((tn < 0) == pos) || ((sn > den) == pos) || ((tn > den) == pos))
			return r;
		dmag = abs_of(den);
		rem = abs_of(tn);
		quo = 0;
		if (rem >= dmag) begin
			quo = 1;
			rem = rem - dmag;
		end
		for (int i = 0; i < T_FRAC_BITS; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= dmag) begin
				rem = rem - dmag;
				quo = quo | 1;
			end
		end
		stepx = (quo * abs_of(d10x)) >> T_FRAC_BITS;
		stepy = (quo * abs_of(d10y)) >> T_FRAC_BITS;
		r.hit = 1'b1;
		r.cross_x = COORD_BITS'((d10x < 0) ? ax - longint'(stepx) : ax + longint'(stepx));
		r.cross_y = COORD_BITS'((d10y < 0) ? ay - longint'(stepy) : ay + longint'(stepy));
		return r;
	endfunction

	function automatic seg_pair_t pair_of(int x0, int y0, int x1, int y1,
		int x2, int y2, int x3, int y3);
		seg_pair_t p;
		p.first_start_x = COORD_BITS'(x0);
		p.first_start_y = COORD_BITS'(y0);
		p.first_end_x = COORD_BITS'(x1);
		p.first_end_y = COORD_BITS'(y1);
		p.second_start_x = COORD_BITS'(x2);
		p.second_start_y = COORD_BITS'(y2);
		p.second_end_x = COORD_BITS'(x3);
		p.second_end_y = COORD_BITS'(y3);
		return p;
	endfunction

	function automatic int rnd(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic int edge_coord();
		case ($urandom_range(7))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 32766;
			6: return 32767;
			default: return rnd(32767);
		endcase
	endfunction

	// Two segments built to cross at a point X on the first one; the second runs
	// from p2 through X or ends on it. Orders are swapped at random so that both
	// signs of the denominator occur, and touching at an end point is frequent.
	function automatic seg_pair_t make_crossing();
		int span, x0, y0, x1, y1, x2, y2, x3, y3, lam, mu, xc, yc, tmp;
		case ($urandom_range(3))
			0: span = 64;
			1: span = 1024;
			default: span = 8000;
		endcase
		x0 = rnd(span);
		y0 = rnd(span);
		x1 = rnd(span);
		y1 = rnd(span);
		x2 = rnd(span);
		y2 = rnd(span);
		case ($urandom_range(7))
			0: lam = 0;
			1: lam = 256;
			default: lam = $urandom_range(256);
		endcase
		mu = ($urandom_range(7) == 0) ? 0 : $urandom_range(256);
		xc = x0 + ((x1 - x0) * lam) / 256;
		yc = y0 + ((y1 - y0) * lam) / 256;
		x3 = xc + ((xc - x2) * mu) / 256;
		y3 = yc + ((yc - y2) * mu) / 256;
		if ($urandom_range(1)) begin
			tmp = x2; x2 = x3; x3 = tmp;
			tmp = y2; y2 = y3; y3 = tmp;
		end
		return pair_of(x0, y0, x1, y1, x2, y2, x3, y3);
	endfunction

	// Parallel, collinear or degenerate segments: the denominator is zero.
	function automatic seg_pair_t make_parallel();
		int x0, y0, dx, dy, x2, y2, k, j;
		x0 = rnd(2000);
		y0 = rnd(2000);
		dx = rnd(2000);
		dy = rnd(2000);
		k = rnd(2);
		j = rnd(2);
		if ($urandom_range(1)) begin
			x2 = x0 + dx * j;
			y2 = y0 + dy * j;
		end else begin
			x2 = rnd(2000);
			y2 = rnd(2000);
		end
		return pair_of(x0, y0, x0 + dx, y0 + dy, x2, y2, x2 + dx * k, y2 + dy * k);
	endfunction

	function automatic seg_pair_t make_random_pair();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return make_crossing();
		if (sel < 62)
			return seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
		if (sel < 72)
			return make_parallel();
		if (sel < 84)
			return pair_of(rnd(64), rnd(64), rnd(64), rnd(64), rnd(64), rnd(64), rnd(64), rnd(64));
		return pair_of(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
			edge_coord(), edge_coord(), edge_coord(), edge_coord());
	endfunction

	// Sender: presents queued pairs, holds a beat while the block is not ready,
	// and records the expected point for every beat that is taken.
	always @(posedge clk) begin : drive_proc
		seg_pair_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_points.push_back(predict_crossing(seg_pair_t'(s_axis_tdata)));
			if (s_axis_tvalid && !s_axis_tready) begin
				// The beat stays on the bus until it is taken.
			end else if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_pairs.pop_front();
				s_axis_tdata <= nxt;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off each time one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_proc
		crossing_t want;
		logic signed [COORD_BITS-1:0] got_x, got_y;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_x = m_axis_tdata[COORD_BITS-1:0];
			got_y = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
			if (expected_points.size() == 0) begin
				$error("result beat with nothing expected: hit %0b x %0d y %0d",
					m_axis_tuser, got_x, got_y);
				mismatch_count++;
			end else begin
				want = expected_points.pop_front();
				if (m_axis_tuser !== want.hit) begin
					$error("hit mismatch: expected %0b, actual %0b", want.hit, m_axis_tuser);
					mismatch_count++;
				end
				if (got_x !== want.cross_x) begin
					$error("cross_x mismatch: expected %0d, actual %0d", want.cross_x, got_x);
					mismatch_count++;
				end
				if (got_y !== want.cross_y) begin
					$error("cross_y mismatch: expected %0d, actual %0d", want.cross_y, got_y);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_pairs.size() != 0 || expected_points.size() != 0 || s_axis_tvalid)
			@(negedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			pending_pairs.push_back(make_random_pair());
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats: degenerate input, plain crossings of both orientations,
		// touching at end points (accepted for a positive denominator, rejected
		// for a negative one), misses past either end and the coordinate extremes.
		pending_pairs.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(pair_of(0, 0, 160, 160, 0, 160, 160, 0));
		pending_pairs.push_back(pair_of(0, 0, 160, 160, 160, 0, 0, 160));
		pending_pairs.push_back(pair_of(160, 160, 0, 0, 0, 160, 160, 0));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 0, 16, 160, 16));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 80, 0, 240, 0));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 80, 0, 80, 160));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 80, 160, 80, 0));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 0, -80, 0, 80));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 0, 80, 0, -80));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 160, -80, 160, 80));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 160, 80, 160, -80));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 200, -80, 200, 80));
		pending_pairs.push_back(pair_of(0, 0, 160, 0, 80, 16, 80, 160));
		pending_pairs.push_back(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		pending_pairs.push_back(pair_of(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
		pending_pairs.push_back(pair_of(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768));
		pending_pairs.push_back(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		pending_pairs.push_back(pair_of(-1, -1, -32768, 32767, -32768, 0, 0, 3));
		pending_pairs.push_back(pair_of(100, 37, -93, -51, -77, 40, 61, -29));
		pending_pairs.push_back(pair_of(-3, 5, 7, -11, 0, -9, 2, 13));
		pending_pairs.push_back(pair_of(32767, 0, -32768, 1, 0, 32767, 1, -32768));
		wait_drained();

		run_phase(0, 0, 350);

		// Long receiver hold-off while the sender keeps offering beats, so the
		// block fills up and has to drop tready on its input.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (200)
			pending_pairs.push_back(make_random_pair());
		hold_seq++;
		wait_drained();

		run_phase(57, 0, 350);
		run_phase(0, 57, 350);
		run_phase(28, 28, 350);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && expected_points.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/segix_pkg.sv
rtl/segix_front.sv
rtl/segix_fifo.sv
rtl/segix_back.sv
rtl/segment_intersection_top.sv
bench/segment_intersection_top_tb.sv
